// ===== rtl/bole_pkg.sv =====
package bole_pkg;

    localparam int DATA_W  = 32;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 5;

    // request codes (s_tuser)
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_TAIL  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd5;

    // status codes (m_tuser)
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // per-cycle cell operations
    localparam logic [2:0] C_HOLD   = 3'd0;
    localparam logic [2:0] C_PUSHF  = 3'd1;  // every cell takes its left neighbor; cell 0 takes value
    localparam logic [2:0] C_PUSHB  = 3'd2;  // cell at pos loads value
    localparam logic [2:0] C_REMOVE = 3'd3;  // cells from first match on take right neighbor
    localparam logic [2:0] C_ROT    = 3'd4;  // cells below pos take right, cell at pos takes head

    typedef struct packed {
        logic [2:0]        op;
        logic [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

// ===== rtl/bole_cell.sv =====
module bole_cell #(
    parameter int CAPACITY = 16,
    parameter int INDEX    = 0
) (
    input  logic                          clk,
    input  bole_pkg::cell_ctl_t           ctl,
    input  logic [$clog2(CAPACITY)-1:0]   pos,
    input  logic [$clog2(CAPACITY+1)-1:0] cnt,
    input  logic [31:0]                   left_data,
    input  logic [31:0]                   right_data,
    input  logic [31:0]                   head_data,
    input  logic                          hit_in,
    output logic                          hit_out,
    output logic [31:0]                   data
);
    import bole_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam logic [IW-1:0] IDX  = IW'(INDEX);
    localparam logic [CW-1:0] IDXC = CW'(INDEX);

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        match;

    assign match   = (data_reg == ctl.value) && (IDXC < cnt);
    assign hit_out = hit_in | match;
    assign data    = data_reg;

    always_comb
    begin
        case (ctl.op)
            C_PUSHF:  data_next = left_data;
            C_PUSHB:  data_next = (IDX == pos) ? ctl.value : data_reg;
            C_REMOVE: data_next = hit_out ? right_data : data_reg;
            C_ROT:
            begin
                if (IDX < pos)
                    data_next = right_data;
                else if (IDX == pos)
                    data_next = head_data;
                else
                    data_next = data_reg;
            end
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/bounded_ordered_list_engine_unit.sv =====
// Push, remove, clear, unused codes, empty reads: one registered result, in the next cycle.
// These requests sustain one transaction per cycle while m_tready stays high.
// Read out: count results from the rotating head cell, one per cycle while m_tready is high.
// Reverse: one registered result, then the chain rotates in S_RV before s_tready returns.
// Reset clears the element count, the sequencer and the output valid; cell contents are not reset.
module bounded_ordered_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic signed [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]         s_tuser,   // [2:0] req_type
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // [31:0] item_value, [36:32] entry_count, rest zero
    output logic [1:0]         m_tuser,   // [1:0] status
    output logic               m_tlast    // is_last
);
    import bole_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_RV   = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next, cnt_m1;
    logic [IW-1:0] pos_reg, pos_next;

    logic              m_tvalid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [31:0]       item_reg;
    logic              last_reg;
    logic [ECNT_W-1:0] ecnt_reg;

    cell_ctl_t     ctl;
    logic [IW-1:0] cell_pos;
    logic [31:0]   cell_data [CAPACITY];
    logic [CAPACITY:0] hit;

    logic              slot_free, accept, full, emit;
    logic [STAT_W-1:0] em_status;
    logic [31:0]       em_item;
    logic              em_last;
    logic [CW+4:0]     cnt_ext;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign full      = (cnt_reg == CW'(CAPACITY));
    assign cnt_m1    = cnt_reg - CW'(1);
    assign hit[0]    = 1'b0;
    assign cnt_ext   = {5'b0, cnt_next};

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [31:0] left_d, right_d;
            if (g == 0)
            begin : g_first
                assign left_d = ctl.value;
            end
            else
            begin : g_mid
                assign left_d = cell_data[g-1];
            end
            if (g == CAPACITY-1)
            begin : g_last
                assign right_d = cell_data[g];
            end
            else
            begin : g_inner
                assign right_d = cell_data[g+1];
            end

            bole_cell #(
                .CAPACITY (CAPACITY),
                .INDEX    (g)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos        (cell_pos),
                .cnt        (cnt_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (cell_data[0]),
                .hit_in     (hit[g]),
                .hit_out    (hit[g+1]),
                .data       (cell_data[g])
            );
        end
    endgenerate

    always_comb
    begin
        ctl.op     = C_HOLD;
        ctl.value  = s_tdata;
        cell_pos   = cnt_reg[IW-1:0];
        cnt_next   = cnt_reg;
        state_next = state_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        em_status  = ST_OK;
        em_item    = '0;
        em_last    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    emit = 1'b1;
                    case (s_tuser)
                        REQ_PUSH_FRONT, REQ_PUSH_TAIL:
                        begin
                            if (full)
                                em_status = ST_FULL;
                            else
                            begin
                                ctl.op   = (s_tuser == REQ_PUSH_FRONT) ? C_PUSHF : C_PUSHB;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        REQ_REMOVE:
                        begin
                            ctl.op = C_REMOVE;
                            if (hit[CAPACITY])
                                cnt_next = cnt_m1;
                            else
                                em_status = ST_MISS;
                        end
                        REQ_REVERSE:
                        begin
                            if (cnt_reg < CW'(2))
                                em_status = ST_MISS;
                            else
                            begin
                                state_next = S_RV;
                                pos_next   = cnt_m1[IW-1:0];
                            end
                        end
                        REQ_CLEAR:
                            cnt_next = '0;
                        REQ_READ:
                        begin
                            if (cnt_reg == '0)
                                em_status = ST_EMPTY;
                            else
                            begin
                                emit       = 1'b0;
                                state_next = S_RD;
                                pos_next   = cnt_m1[IW-1:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:
            begin
                if (slot_free)
                begin
                    ctl.op   = C_ROT;
                    cell_pos = cnt_m1[IW-1:0];
                    emit     = 1'b1;
                    em_item  = cell_data[0];
                    em_last  = (pos_reg == '0);
                    pos_next = pos_reg - IW'(1);
                    if (pos_reg == '0)
                        state_next = S_IDLE;
                end
            end
            S_RV:
            begin
                // pop head, drop it at pos; pos walks down toward the front
                ctl.op   = C_ROT;
                cell_pos = pos_reg;
                pos_next = pos_reg - IW'(1);
                if (pos_reg == IW'(1))
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= em_status;
            item_reg   <= em_item;
            last_reg   <= em_last;
            ecnt_reg   <= cnt_ext[ECNT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b0, ecnt_reg, item_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken while sequencing");

    a_rd_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD && slot_free && pos_reg == '0) |=> (state_reg == S_IDLE && m_tlast))
        else $error("read out did not finish on last element");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == REQ_CLEAR) |=> (cnt_reg == '0 && m_tvalid))
        else $error("clear did not empty the list");

    a_rv_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RV) |=> $stable(cnt_reg))
        else $error("count changed during reverse");

endmodule

// ===== sim/bounded_ordered_list_engine_unit_tb.sv =====
`timescale 1ns / 100ps

module bounded_ordered_list_engine_unit_tb;
    import bole_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int RAND_ITEMS  = 480;
    localparam int TAIL_ITEMS  = 50;
    localparam int LONG_HOLD   = 120;
    localparam int TAIL_CYCLES = 2 * CAPACITY + 8;

    // codes the block does not define; it must answer them with a plain ok
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    typedef struct {
        logic [REQ_W-1:0]        req;
        logic signed [DATA_W-1:0] value;
        bit                       sync_point;  // wait here until all results are back
    } list_req_t;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] item_value;
        logic                     is_last;
        logic [ECNT_W-1:0]        entry_count;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic signed [31:0] s_tdata = '0;
    logic [2:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [39:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    bounded_ordered_list_engine_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    list_req_t               pending_reqs[$];
    list_result_t            expected_results[$];
    logic signed [DATA_W-1:0] list_vals[CAPACITY];
    int                      list_len;

    int  failures;
    int  reqs_sent;
    int  reqs_accepted;
    int  results_seen;
    int  full_drops;
    int  miss_count;
    int  readouts;
    int  sync_pauses;
    int  long_holds;
    bit  tail_phase;
    int  send_gap;
    int  sink_hold;

    // ordered list, position 0 is the front
    task automatic predict_request(input logic [REQ_W-1:0] req,
                                   input logic signed [DATA_W-1:0] val);
        list_result_t             res;
        int                       i;
        int                       hit;
        logic signed [DATA_W-1:0] tmp;
        res.status     = ST_OK;
        res.item_value = '0;
        res.is_last    = 1'b1;
        case (req)
            REQ_PUSH_FRONT:
            begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i > 0; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[0] = val;
                    list_len++;
                end
            end
            REQ_PUSH_TAIL:
            begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_vals[list_len] = val;
                    list_len++;
                end
            end
            REQ_REMOVE:
            begin
                hit = -1;
                for (i = 0; i < list_len; i++)
                    if (hit < 0 && list_vals[i] == val)
                        hit = i;
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    for (i = hit; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
            REQ_REVERSE:
            begin
                if (list_len < 2) begin
                    res.status = ST_MISS;
                end else begin
                    for (i = 0; i < list_len / 2; i++) begin
                        tmp = list_vals[i];
                        list_vals[i] = list_vals[list_len-1-i];
                        list_vals[list_len-1-i] = tmp;
                    end
                end
            end
            REQ_CLEAR:
                list_len = 0;
            default: ;
        endcase
        res.entry_count = list_len[ECNT_W-1:0];
        if (res.status == ST_FULL)
            full_drops++;
        if (res.status == ST_MISS)
            miss_count++;

        if (req == REQ_READ) begin
            readouts++;
            if (list_len == 0) begin
                res.status = ST_EMPTY;
                expected_results.insert(expected_results.size(), res);
            end else begin
                for (i = 0; i < list_len; i++) begin
                    res.item_value = list_vals[i];
                    res.is_last    = (i + 1 == list_len);
                    expected_results.insert(expected_results.size(), res);
                end
            end
        end else begin
            expected_results.insert(expected_results.size(), res);
        end
    endtask

    // sender: one transaction in flight, random gaps after acceptance
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        int   idle_pct;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata);
                reqs_accepted++;
            end
            tail_phase = (pending_reqs.size() < TAIL_ITEMS);
            case ((reqs_sent / 50) % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 20;
                default: idle_pct = 50;
            endcase
            next_valid = s_tvalid && !s_tready;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0) begin
                    if (pending_reqs[0].sync_point) begin
                        if (!s_tvalid && expected_results.size() == 0) begin
                            void'(pending_reqs.pop_front());
                            sync_pauses++;
                        end
                    end else begin
                        s_tuser <= pending_reqs[0].req;
                        s_tdata <= pending_reqs[0].value;
                        void'(pending_reqs.pop_front());
                        next_valid = 1'b1;
                        reqs_sent++;
                        if (!tail_phase && $urandom_range(0, 99) < idle_pct)
                            send_gap = $urandom_range(1, 6);
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // receiver: checks each result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        int           stall_pct;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d item_value %0d last %0b count %0d",
                           m_tuser, $signed(m_tdata[31:0]), m_tlast, m_tdata[36:32]);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        failures++;
                    end
                    if ($signed(m_tdata[31:0]) !== want.item_value) begin
                        $error("item_value: expected %0d, got %0d",
                               want.item_value, $signed(m_tdata[31:0]));
                        failures++;
                    end
                    if (m_tlast !== want.is_last) begin
                        $error("is_last: expected %0b, got %0b", want.is_last, m_tlast);
                        failures++;
                    end
                    if (m_tdata[36:32] !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_tdata[36:32]);
                        failures++;
                    end
                end
                // long back-pressure so the output slot stays full and the block stalls its input
                if (results_seen == 40 || results_seen == 250) begin
                    sink_hold = LONG_HOLD;
                    long_holds++;
                end
            end
            case ((results_seen / 60) % 3)
                0:       stall_pct = 30;
                1:       stall_pct = 0;
                default: stall_pct = 60;
            endcase
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
                sink_hold = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic add_req(input logic [REQ_W-1:0] req, input logic signed [DATA_W-1:0] val);
        list_req_t r;
        r.req        = req;
        r.value      = val;
        r.sync_point = 1'b0;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic add_sync();
        list_req_t r;
        r.req        = REQ_PUSH_FRONT;
        r.value      = '0;
        r.sync_point = 1'b1;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // small values give duplicates and remove hits; the rest covers every bit
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: pick_value = $signed($urandom_range(0, 9)) - 5;
            5, 6, 7:       pick_value = $urandom;
            8:             pick_value = 32'sh7fffffff;
            default:       pick_value = 32'sh80000000;
        endcase
    endfunction

    initial
    begin
        int n;
        int seg_len;
        int push_pct;
        int r;
        int cycles;

        // directed: empty-list corner cases, extremes, every request code
        add_req(REQ_READ, 32'sd0);
        add_req(REQ_REVERSE, 32'sd0);
        add_req(REQ_REMOVE, 32'sd5);
        add_req(REQ_PUSH_FRONT, 32'sh7fffffff);
        add_req(REQ_REVERSE, 32'sd0);
        add_req(REQ_PUSH_TAIL, 32'sh80000000);
        add_req(REQ_PUSH_FRONT, 32'sd0);
        add_req(REQ_PUSH_TAIL, -32'sd1);
        add_req(REQ_READ, 32'sd0);
        add_req(REQ_REVERSE, 32'sd0);
        add_req(REQ_READ, 32'sd0);
        add_req(REQ_REMOVE, -32'sd1);
        add_req(REQ_REMOVE, 32'sd12345);
        add_req(REQ_SPARE_A, $urandom);
        add_req(REQ_SPARE_B, $urandom);
        add_req(REQ_REMOVE, 32'sh7fffffff);
        add_req(REQ_READ, 32'sd0);
        add_req(REQ_CLEAR, 32'sd0);
        add_req(REQ_READ, 32'sd0);
        add_sync();

        // fill to capacity, then push into a full list from both ends
        for (n = 0; n < CAPACITY; n++)
            add_req(n[0] ? REQ_PUSH_TAIL : REQ_PUSH_FRONT, pick_value());
        add_req(REQ_PUSH_FRONT, 32'sd77);
        add_req(REQ_PUSH_TAIL, 32'sd78);
        add_req(REQ_READ, 32'sd0);
        add_req(REQ_REVERSE, 32'sd0);
        add_req(REQ_READ, 32'sd0);
        n = CAPACITY + 5;

        // random segments, each biased toward growing or shrinking the list, or balanced
        while (n < RAND_ITEMS) begin
            seg_len = $urandom_range(8, 30);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 20;
            endcase
            repeat (seg_len) begin
                r = $urandom_range(0, 99);
                if (r < push_pct) begin
                    add_req($urandom_range(0, 1) ? REQ_PUSH_TAIL : REQ_PUSH_FRONT,
                            pick_value());
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        add_req(REQ_REMOVE, pick_value());
                    else if (r < 70)
                        add_req(REQ_READ, $urandom);
                    else if (r < 88)
                        add_req(REQ_REVERSE, $urandom);
                    else if (r < 96)
                        add_req(REQ_CLEAR, $urandom);
                    else
                        add_req($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B, $urandom);
                end
                n++;
            end
            if ($urandom_range(0, 5) == 0)
                add_sync();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        for (cycles = 0; cycles < TAIL_CYCLES; cycles++)
            @(posedge clk);
        if (expected_results.size() > 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            failures++;
        end

        $display("%0d requests through, %0d results checked (%0d read-outs, %0d full drops,",
                 reqs_accepted, results_seen, readouts, full_drops);
        $display("%0d misses or refused reverses), %0d sync pauses, %0d long back-pressure holds",
                 miss_count, sync_pauses, long_holds);
        if (failures == 0)
            $display("bounded_ordered_list_engine_unit test passed");
        else
            $display("bounded_ordered_list_engine_unit test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("bounded_ordered_list_engine_unit test failed");
        $finish;
    end

endmodule
